// ----- hw/rtl/kvt_pkg.sv -----
// ----------------------------------------------------------------------------
// kvt_pkg
// Shared types for the keyed put/take table: request and response layouts,
// action and status codes.
// ----------------------------------------------------------------------------
package kvt_pkg;

    localparam int KEY_W   = 16;
    localparam int VALUE_W = 16;
    localparam int ENTRY_W = KEY_W + VALUE_W;

    typedef enum logic {
        ACT_PUT  = 1'b0,
        ACT_TAKE = 1'b1
    } action_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_EMPTY   = 2'd2,
        ST_MISSING = 2'd3
    } status_t;

    typedef struct packed {
        action_t                    action;
        logic [KEY_W-1:0]           key;
        logic signed [VALUE_W-1:0]  value;
    } kvt_req_t;

    typedef struct packed {
        status_t                    status;
        logic [KEY_W-1:0]           out_key;
        logic signed [VALUE_W-1:0]  out_value;
    } kvt_resp_t;

endpackage

// ----- hw/rtl/keyed_table_put_take.sv -----
// ----------------------------------------------------------------------------
// keyed_table_put_take
// Unordered key/value table with linear search: put inserts or updates,
// take looks a key up and removes it.
// ----------------------------------------------------------------------------
// One request is handled at a time. A request refused as full or empty, or a
// put into an empty table, is answered without a scan. Any other request
// first scans the slots in order, comparing 1 to fill count of them, and a
// take that moves the last entry into the freed slot then does that move.
// The scan reads one stored entry from the single-read-port table memory
// and compares it, one entry per cycle.
// Requests are accepted while an earlier response is still held on the
// output; the sequencer only waits at the end if that response is not taken.
// ----------------------------------------------------------------------------
module keyed_table_put_take #(
    parameter int CAPACITY = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  kvt_pkg::kvt_req_t  s_req,
    output logic               m_valid,
    input  logic               m_ready,
    output kvt_pkg::kvt_resp_t m_resp
);

    import kvt_pkg::*;

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SCAN = 4'b0010,
        S_MOVE = 4'b0100,
        S_DONE = 4'b1000
    } state_t;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    kvt_req_t           req_reg, req_next;
    kvt_resp_t          pend_reg, pend_next;
    kvt_resp_t          resp_reg;
    logic               m_valid_reg;
    logic [IDX_W-1:0]   cmp_idx_reg, cmp_idx_next;
    logic [IDX_W-1:0]   hit_idx_reg, hit_idx_next;
    logic               load_resp;

    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    logic [ENTRY_W-1:0] wr_data;
    logic [IDX_W-1:0]   rd_addr;
    logic [ENTRY_W-1:0] rd_data;

    logic [KEY_W-1:0]   rd_key;
    logic [IDX_W-1:0]   last_idx;
    logic               hit;
    logic               at_last;

    kvt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CAPACITY)
    ) u_slots (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign rd_key   = rd_data[ENTRY_W-1:VALUE_W];
    assign last_idx = IDX_W'(count_reg - CNT_W'(1));
    assign hit      = (rd_key == req_reg.key);
    assign at_last  = (cmp_idx_reg == last_idx);

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_resp  = resp_reg;

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        req_next     = req_reg;
        pend_next    = pend_reg;
        cmp_idx_next = cmp_idx_reg;
        hit_idx_next = hit_idx_reg;
        load_resp    = 1'b0;
        wr_en        = 1'b0;
        wr_addr      = '0;
        wr_data      = '0;
        rd_addr      = '0;

        unique case (state_reg)
            S_IDLE: begin
                cmp_idx_next = '0;
                if (s_valid) begin
                    req_next  = s_req;
                    pend_next = '{status: ST_OK, out_key: '0, out_value: '0};
                    if (s_req.action == ACT_PUT) begin
                        if (count_reg == CNT_W'(CAPACITY)) begin
                            pend_next.status = ST_FULL;
                            state_next       = S_DONE;
                        end else if (count_reg == '0) begin
                            // nothing to search, append straight away
                            wr_en      = 1'b1;
                            wr_addr    = '0;
                            wr_data    = {s_req.key, s_req.value};
                            count_next = CNT_W'(1);
                            state_next = S_DONE;
                        end else begin
                            state_next = S_SCAN;
                        end
                    end else begin
                        if (count_reg == '0) begin
                            pend_next.status = ST_EMPTY;
                            state_next       = S_DONE;
                        end else begin
                            state_next = S_SCAN;
                        end
                    end
                end
            end

            S_SCAN: begin
                // read of the next slot overlaps the compare of this one
                rd_addr = cmp_idx_reg + IDX_W'(1);
                if (hit) begin
                    if (req_reg.action == ACT_PUT) begin
                        wr_en      = 1'b1;
                        wr_addr    = cmp_idx_reg;
                        wr_data    = {req_reg.key, req_reg.value};
                        state_next = S_DONE;
                    end else begin
                        pend_next.out_key   = rd_key;
                        pend_next.out_value = signed'(rd_data[VALUE_W-1:0]);
                        if (at_last) begin
                            count_next = count_reg - CNT_W'(1);
                            state_next = S_DONE;
                        end else begin
                            // fetch the last entry to fill the hole
                            rd_addr      = last_idx;
                            hit_idx_next = cmp_idx_reg;
                            state_next   = S_MOVE;
                        end
                    end
                end else if (at_last) begin
                    if (req_reg.action == ACT_PUT) begin
                        wr_en      = 1'b1;
                        wr_addr    = count_reg[IDX_W-1:0];
                        wr_data    = {req_reg.key, req_reg.value};
                        count_next = count_reg + CNT_W'(1);
                    end else begin
                        pend_next.status = ST_MISSING;
                    end
                    state_next = S_DONE;
                end else begin
                    cmp_idx_next = cmp_idx_reg + IDX_W'(1);
                end
            end

            S_MOVE: begin
                wr_en      = 1'b1;
                wr_addr    = hit_idx_reg;
                wr_data    = rd_data;
                count_next = count_reg - CNT_W'(1);
                state_next = S_DONE;
            end

            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    load_resp  = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (load_resp) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        req_reg     <= req_next;
        pend_reg    <= pend_next;
        cmp_idx_reg <= cmp_idx_next;
        hit_idx_reg <= hit_idx_next;
        if (load_resp) begin
            resp_reg <= pend_reg;
        end
    end

    // table never holds more than its capacity
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(CAPACITY))
        else $error("fill count above capacity");

    // fill count moves by at most one per cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg != $past(count_reg)) |->
            (count_reg == $past(count_reg) + CNT_W'(1) ||
             count_reg == $past(count_reg) - CNT_W'(1)))
        else $error("fill count jumped");

    // take from an empty table answers empty and leaves the count alone
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_req.action == ACT_TAKE && count_reg == '0) |=>
            (pend_reg.status == ST_EMPTY && count_reg == '0))
        else $error("take on empty table mishandled");

    // only a successful take carries a key
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_resp.status == ST_OK || m_resp.out_key == '0))
        else $error("key on a failed response");

endmodule

// ----- hw/rtl/kvt_ram.sv -----
// ----------------------------------------------------------------------------
// kvt_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read.
// ----------------------------------------------------------------------------
module kvt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                     aclk,
    input  logic                                     wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                         wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- bench/keyed_table_put_take_tb.sv -----
// ----------------------------------------------------------------------------
// keyed_table_put_take_tb
// Self-checking bench for the keyed put/take table. A short table of directed
// requests covers the empty, full, update, miss and move-last cases; random
// traffic then follows, with put/take mix drifting so the table fills and
// drains repeatedly. Each response is checked against a behavioural shadow of the table or a
// typed answer, under random idling and back-pressure on both channels until the calm stretch.
// ----------------------------------------------------------------------------
module keyed_table_put_take_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import kvt_pkg::*;

    localparam int SLOTS       = 16;
    localparam int PROBE_COUNT = 27;
    localparam int RANDOM_REQS = 1050;
    localparam int CALM_FROM   = 900;
    localparam int POOL_SIZE   = 24;

    typedef struct packed {
        kvt_req_t  req;
        logic      known;
        kvt_resp_t resp;
    } probe_row_t;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    kvt_req_t  s_req;
    logic      m_valid;
    logic      m_ready;
    kvt_resp_t m_resp;

    // shadow of the table contents
    logic [KEY_W-1:0]          shadow_keys [SLOTS];
    logic signed [VALUE_W-1:0] shadow_values [SLOTS];
    int                        shadow_fill = 0;

    kvt_resp_t  pending_resps[$];
    kvt_resp_t  want_resp;
    probe_row_t probe_rows [PROBE_COUNT];
    logic [KEY_W-1:0] key_pool [POOL_SIZE];

    int  mismatches = 0;
    int  puts_sent = 0;
    int  takes_sent = 0;
    int  status_seen [4];
    bit  calm = 1'b0;

    keyed_table_put_take #(
        .CAPACITY(SLOTS)
    ) i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_req   (s_req),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_resp  (m_resp)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // applies one request to the shadow table and returns its response
    function automatic kvt_resp_t table_apply(kvt_req_t req);
        kvt_resp_t resp;
        int        hit;
        int        last;
        resp = '{status: ST_OK, out_key: '0, out_value: '0};
        hit = -1;
        for (int i = 0; i < shadow_fill; i++) begin
            if (hit < 0 && shadow_keys[i] == req.key) begin
                hit = i;
            end
        end
        if (req.action == ACT_PUT) begin
            if (shadow_fill >= SLOTS) begin
                resp.status = ST_FULL;
            end else if (hit >= 0) begin
                shadow_values[hit] = req.value;
            end else begin
                shadow_keys[shadow_fill] = req.key;
                shadow_values[shadow_fill] = req.value;
                shadow_fill++;
            end
        end else begin
            if (shadow_fill == 0) begin
                resp.status = ST_EMPTY;
            end else if (hit < 0) begin
                resp.status = ST_MISSING;
            end else begin
                last = shadow_fill - 1;
                resp.out_key = shadow_keys[hit];
                resp.out_value = shadow_values[hit];
                shadow_keys[hit] = shadow_keys[last];
                shadow_values[hit] = shadow_values[last];
                shadow_fill = last;
            end
        end
        return resp;
    endfunction

    function automatic probe_row_t mk_row(action_t a, logic [KEY_W-1:0] k,
                                          logic [VALUE_W-1:0] v, logic known,
                                          status_t st, logic [KEY_W-1:0] rk,
                                          logic [VALUE_W-1:0] rv);
        probe_row_t row;
        row.req.action = a;
        row.req.key = k;
        row.req.value = v;
        row.known = known;
        row.resp.status = st;
        row.resp.out_key = rk;
        row.resp.out_value = rv;
        return row;
    endfunction

    // presents one request, holds it until taken, then maybe idles
    task automatic issue(kvt_req_t req, logic known, kvt_resp_t typed);
        kvt_resp_t predicted;
        predicted = table_apply(req);
        pending_resps.push_back(known ? typed : predicted);
        if (req.action == ACT_PUT) begin
            puts_sent++;
        end else begin
            takes_sent++;
        end
        s_valid <= 1'b1;
        s_req <= req;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (!calm && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge aclk);
        end
    endtask

    initial begin
        // after reset, extremes, update, miss, take with move
        probe_rows[0]  = mk_row(ACT_TAKE, 16'h0000, 16'h7fff, 1'b1, ST_EMPTY, 16'h0, 16'h0);
        probe_rows[1]  = mk_row(ACT_PUT,  16'h0000, 16'h8000, 1'b1, ST_OK, 16'h0, 16'h0);
        probe_rows[2]  = mk_row(ACT_PUT,  16'hffff, 16'h7fff, 1'b1, ST_OK, 16'h0, 16'h0);
        probe_rows[3]  = mk_row(ACT_PUT,  16'h0000, 16'h1234, 1'b1, ST_OK, 16'h0, 16'h0);
        probe_rows[4]  = mk_row(ACT_TAKE, 16'h8000, 16'hffff, 1'b1, ST_MISSING, 16'h0, 16'h0);
        probe_rows[5]  = mk_row(ACT_TAKE, 16'h0000, 16'h0000, 1'b0, ST_OK, 16'h0, 16'h0);
        probe_rows[6]  = mk_row(ACT_TAKE, 16'hffff, 16'h0000, 1'b0, ST_OK, 16'h0, 16'h0);
        // fill every slot
        probe_rows[7]  = mk_row(ACT_PUT,  16'h0000, 16'h8001, 1'b0, ST_OK, 16'h0, 16'h0);
        probe_rows[8]  = mk_row(ACT_PUT,  16'h1111, 16'h7ffe, 1'b0, ST_OK, 16'h0, 16'h0);
        probe_rows[9]  = mk_row(ACT_PUT,  16'h2222, 16'hffff, 1'b0, ST_OK, 16'h0, 16'h0);
        probe_rows[10] = mk_row(ACT_PUT,  16'h3333, 16'h0001, 1'b0, ST_OK, 16'h0, 16'h0);
        probe_rows[11] = mk_row(ACT_PUT,  16'h4444, 16'h5a5a, 1'b0, ST_OK, 16'h0, 16'h0);
        probe_rows[12] = mk_row(ACT_PUT,  16'h5555, 16'ha5a5, 1'b0, ST_OK, 16'h0, 16'h0);
        probe_rows[13] = mk_row(ACT_PUT,  16'h6666, 16'h0f0f, 1'b0, ST_OK, 16'h0, 16'h0);
        probe_rows[14] = mk_row(ACT_PUT,  16'h7777, 16'hf0f0, 1'b0, ST_OK, 16'h0, 16'h0);
        probe_rows[15] = mk_row(ACT_PUT,  16'h8888, 16'h3c3c, 1'b0, ST_OK, 16'h0, 16'h0);
        probe_rows[16] = mk_row(ACT_PUT,  16'h9999, 16'hc3c3, 1'b0, ST_OK, 16'h0, 16'h0);
        probe_rows[17] = mk_row(ACT_PUT,  16'haaaa, 16'h00ff, 1'b0, ST_OK, 16'h0, 16'h0);
        probe_rows[18] = mk_row(ACT_PUT,  16'hbbbb, 16'hff00, 1'b0, ST_OK, 16'h0, 16'h0);
        probe_rows[19] = mk_row(ACT_PUT,  16'hcccc, 16'h1357, 1'b0, ST_OK, 16'h0, 16'h0);
        probe_rows[20] = mk_row(ACT_PUT,  16'hdddd, 16'hecab, 1'b0, ST_OK, 16'h0, 16'h0);
        probe_rows[21] = mk_row(ACT_PUT,  16'heeee, 16'h2468, 1'b0, ST_OK, 16'h0, 16'h0);
        probe_rows[22] = mk_row(ACT_PUT,  16'hffff, 16'hdb97, 1'b0, ST_OK, 16'h0, 16'h0);
        // full: refused even for a key already present
        probe_rows[23] = mk_row(ACT_PUT,  16'h3333, 16'h4321, 1'b1, ST_FULL, 16'h0, 16'h0);
        probe_rows[24] = mk_row(ACT_PUT,  16'habcd, 16'h4321, 1'b1, ST_FULL, 16'h0, 16'h0);
        // take from the middle moves the last entry, then drop the last slot
        probe_rows[25] = mk_row(ACT_TAKE, 16'h3333, 16'h0000, 1'b0, ST_OK, 16'h0, 16'h0);
        probe_rows[26] = mk_row(ACT_TAKE, 16'heeee, 16'h0000, 1'b0, ST_OK, 16'h0, 16'h0);
    end

    initial begin : stimulus
        kvt_req_t req;
        int       put_pct;
        int       pick;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_req = '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        for (int n = 0; n < PROBE_COUNT; n++) begin
            issue(probe_rows[n].req, probe_rows[n].known, probe_rows[n].resp);
        end

        for (int i = 0; i < POOL_SIZE; i++) begin
            key_pool[i] = KEY_W'($urandom);
        end
        put_pct = 50;
        for (int n = 0; n < RANDOM_REQS; n++) begin
            // drift the mix so the table swings between full and empty
            if (n % 100 == 0) begin
                put_pct = $urandom_range(15, 85);
            end
            if (n == CALM_FROM) begin
                calm = 1'b1;
            end
            req.action = ($urandom_range(0, 99) < put_pct) ? ACT_PUT : ACT_TAKE;
            req.value = VALUE_W'($urandom);
            pick = $urandom_range(0, 99);
            if (req.action == ACT_PUT) begin
                if (pick < 70) begin
                    req.key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
                end else if (pick < 85 && shadow_fill > 0) begin
                    req.key = shadow_keys[$urandom_range(0, shadow_fill - 1)];
                end else begin
                    req.key = KEY_W'($urandom);
                end
            end else begin
                if (pick < 60 && shadow_fill > 0) begin
                    req.key = shadow_keys[$urandom_range(0, shadow_fill - 1)];
                end else if (pick < 85) begin
                    req.key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
                end else begin
                    req.key = KEY_W'($urandom);
                end
            end
            issue(req, 1'b0, '0);
        end
        s_valid <= 1'b0;

        while (pending_resps.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);

        $display("%0d puts and %0d takes sent", puts_sent, takes_sent);
        $display("responses: %0d ok, %0d full, %0d empty, %0d not found",
                 status_seen[ST_OK], status_seen[ST_FULL],
                 status_seen[ST_EMPTY], status_seen[ST_MISSING]);
        if (mismatches == 0 && pending_resps.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // response back-pressure
    initial begin
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            if (!calm && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge aclk);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_resps.size() == 0) begin
                $error("response with no request outstanding: status %0d key %h value %h",
                       m_resp.status, m_resp.out_key, m_resp.out_value);
                mismatches++;
            end else begin
                want_resp = pending_resps.pop_front();
                if (m_resp.status !== want_resp.status) begin
                    $error("status: expected %0d, got %0d", want_resp.status, m_resp.status);
                    mismatches++;
                end
                if (m_resp.out_key !== want_resp.out_key) begin
                    $error("out_key: expected %h, got %h", want_resp.out_key, m_resp.out_key);
                    mismatches++;
                end
                if (m_resp.out_value !== want_resp.out_value) begin
                    $error("out_value: expected %0d, got %0d",
                           want_resp.out_value, m_resp.out_value);
                    mismatches++;
                end
                status_seen[want_resp.status]++;
            end
        end
    end

    initial begin
        #3ms;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/kvt_pkg.sv
hw/rtl/kvt_ram.sv
hw/rtl/keyed_table_put_take.sv
bench/keyed_table_put_take_tb.sv
